@@ hw/rtl/bbj_pkg.sv @@
// ----------------------------------------------------------------------------
// bbj_pkg
// Shared constants and helpers for the byte-byte-jump frame engine.
// ----------------------------------------------------------------------------
package bbj_pkg;

  // Byte memory holds 2**ADDR_BITS bytes (16..24).
  localparam int ADDR_BITS       = 24;
  // Instructions executed by one run-frame item (1..65536).
  localparam int INSTR_PER_FRAME = 65536;

  // Addresses as carried by the machine: 24 bits plus one carry bit for
  // the fetch offsets that run past the last byte.
  localparam int AEXT_W = 25;
  localparam int CNT_W  = $clog2(INSTR_PER_FRAME + 1);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;

  // True when the address falls inside the byte memory.
  function automatic logic addr_ok(logic [AEXT_W-1:0] a);
    return (a >> ADDR_BITS) == '0;
  endfunction

endpackage

@@ hw/rtl/bbj_ram.sv @@
// ----------------------------------------------------------------------------
// bbj_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module bbj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ hw/rtl/byte_byte_jump_frame_engine_unit.sv @@
// ----------------------------------------------------------------------------
// byte_byte_jump_frame_engine_unit
// Byte-byte-jump machine on a single-port byte memory: host loads and reads,
// and run-frame items that execute a fixed count of copy-and-jump steps.
// ----------------------------------------------------------------------------
// channel | direction | tdata                                   | tuser  | tlast
// in_     | slave     | address, write_data, key_map            | opcode | -
// out_    | master    | read_data, screen_bank, audio_page      | -      | frame_done
//
// Every state that touches memory spends the one port on a single byte access.
// Load: one byte write; read: one byte read; each is followed by a result.
// Run frame: accept, two key writes, a header fetch of the start address, then per
// instruction nine fetch reads, the source read and the destination write, then a
// tail fetch of the reported bytes and the result.
// Reset is synchronous; memory contents are undefined until written.
// A new item is taken while a result waits; a full result register
// stalls the sequencer in its result state only.
// ----------------------------------------------------------------------------
module byte_byte_jump_frame_engine_unit
  import bbj_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // address[23:0], write_data[31:24], key_map[47:32]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data[7:0], screen_bank[15:8], audio_page[31:16]
  output logic        out_tlast   // frame_done
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOAD   = 8'b0000_0010,
    ST_KEY_HI = 8'b0000_0100,
    ST_KEY_LO = 8'b0000_1000,
    ST_FETCH  = 8'b0001_0000,
    ST_LAST   = 8'b0010_0000,
    ST_COPY   = 8'b0100_0000,
    ST_RESP   = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_HDR   = 2'd1,
    MODE_INSTR = 2'd2,
    MODE_TAIL  = 2'd3
  } mode_t;

  localparam logic [CNT_W-1:0] LAST_INSTR = CNT_W'(INSTR_PER_FRAME - 1);

  state_t               state_r,  state_nxt;
  mode_t                mode_r,   mode_nxt;
  logic [3:0]           fcnt_r,   fcnt_nxt;
  logic [23:0]          pc_r,     pc_nxt;
  logic [CNT_W-1:0]     count_r,  count_nxt;
  logic [71:0]          buf_r,    buf_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic                 rd_zero_r, rd_zero_nxt;
  logic [23:0]          addr_r,   addr_nxt;
  logic [7:0]           wdata_r,  wdata_nxt;
  logic [15:0]          keys_r,   keys_nxt;
  logic [7:0]           res_rdata_r, res_rdata_nxt;
  logic                 res_done_r,  res_done_nxt;
  logic [7:0]           res_bank_r,  res_bank_nxt;
  logic [15:0]          res_audio_r, res_audio_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_data_r,  out_data_nxt;
  logic                 out_last_r,  out_last_nxt;

  logic                 ram_en;
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;

  logic                 in_xfer;
  logic [7:0]           rbyte;
  logic [AEXT_W-1:0]    fetch_base;
  logic [AEXT_W-1:0]    fetch_addr;
  logic [3:0]           fetch_last;
  logic [AEXT_W-1:0]    src_addr;
  logic [AEXT_W-1:0]    dst_addr;
  logic [AEXT_W-1:0]    load_addr;

  bbj_ram #(
    .WIDTH (8),
    .DEPTH (2 ** ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Reads beyond the top of memory never touch the RAM and return zero.
  assign rbyte = rd_zero_r ? 8'd0 : ram_rdata;

  assign src_addr  = {1'b0, buf_r[63:40]};
  assign dst_addr  = {1'b0, buf_r[47:24]};
  assign load_addr = {1'b0, addr_r};

  always_comb begin
    unique case (mode_r)
      MODE_READ: begin
        fetch_base = {1'b0, addr_r};
        fetch_last = 4'd0;
      end
      MODE_HDR: begin
        fetch_base = AEXT_W'(2);
        fetch_last = 4'd2;
      end
      MODE_INSTR: begin
        fetch_base = {1'b0, pc_r};
        fetch_last = 4'd8;
      end
      MODE_TAIL: begin
        fetch_base = AEXT_W'(5);
        fetch_last = 4'd2;
      end
      default: begin
        fetch_base = '0;
        fetch_last = 4'd0;
      end
    endcase
  end

  assign fetch_addr = fetch_base + AEXT_W'(fcnt_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    fcnt_nxt      = fcnt_r;
    pc_nxt        = pc_r;
    count_nxt     = count_r;
    buf_nxt       = buf_r;
    rd_pend_nxt   = 1'b0;
    rd_zero_nxt   = 1'b0;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    keys_nxt      = keys_r;
    res_rdata_nxt = res_rdata_r;
    res_done_nxt  = res_done_r;
    res_bank_nxt  = res_bank_r;
    res_audio_nxt = res_audio_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = '0;
    ram_wdata     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          addr_nxt      = in_tdata[23:0];
          wdata_nxt     = in_tdata[31:24];
          keys_nxt      = in_tdata[47:32];
          res_rdata_nxt = '0;
          res_done_nxt  = 1'b0;
          res_bank_nxt  = '0;
          res_audio_nxt = '0;
          fcnt_nxt      = '0;
          unique case (in_tuser)
            OP_LOAD:  state_nxt = ST_LOAD;
            OP_READ: begin
              mode_nxt  = MODE_READ;
              state_nxt = ST_FETCH;
            end
            OP_FRAME: state_nxt = ST_KEY_HI;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_LOAD: begin
        ram_en    = addr_ok(load_addr);
        ram_we    = 1'b1;
        ram_addr  = load_addr[ADDR_BITS-1:0];
        ram_wdata = wdata_r;
        state_nxt = ST_RESP;
      end
      ST_KEY_HI: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = ADDR_BITS'(0);
        ram_wdata = keys_r[15:8];
        state_nxt = ST_KEY_LO;
      end
      ST_KEY_LO: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = ADDR_BITS'(1);
        ram_wdata = keys_r[7:0];
        count_nxt = '0;
        mode_nxt  = MODE_HDR;
        fcnt_nxt  = '0;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        // Issue one byte read per cycle; capture the byte from the last one.
        ram_en      = addr_ok(fetch_addr);
        ram_addr    = fetch_addr[ADDR_BITS-1:0];
        rd_pend_nxt = 1'b1;
        rd_zero_nxt = !addr_ok(fetch_addr);
        if (rd_pend_r) begin
          buf_nxt = {buf_r[63:0], rbyte};
        end
        if (fcnt_r == fetch_last) begin
          state_nxt = ST_LAST;
        end else begin
          fcnt_nxt = fcnt_r + 4'd1;
        end
      end
      ST_LAST: begin
        unique case (mode_r)
          MODE_READ: begin
            res_rdata_nxt = rbyte;
            state_nxt     = ST_RESP;
          end
          MODE_HDR: begin
            pc_nxt    = {buf_r[15:0], rbyte};
            mode_nxt  = MODE_INSTR;
            fcnt_nxt  = '0;
            state_nxt = ST_FETCH;
          end
          MODE_INSTR: begin
            // Source address is complete already: start its read now.
            buf_nxt     = {buf_r[63:0], rbyte};
            ram_en      = addr_ok(src_addr);
            ram_addr    = src_addr[ADDR_BITS-1:0];
            rd_pend_nxt = 1'b1;
            rd_zero_nxt = !addr_ok(src_addr);
            state_nxt   = ST_COPY;
          end
          MODE_TAIL: begin
            res_done_nxt  = 1'b1;
            res_bank_nxt  = buf_r[15:8];
            res_audio_nxt = {buf_r[7:0], rbyte};
            state_nxt     = ST_RESP;
          end
          default: state_nxt = ST_RESP;
        endcase
      end
      ST_COPY: begin
        ram_en    = addr_ok(dst_addr);
        ram_we    = 1'b1;
        ram_addr  = dst_addr[ADDR_BITS-1:0];
        ram_wdata = rbyte;
        pc_nxt    = buf_r[23:0];
        count_nxt = count_r + CNT_W'(1);
        fcnt_nxt  = '0;
        mode_nxt  = (count_r == LAST_INSTR) ? MODE_TAIL : MODE_INSTR;
        state_nxt = ST_FETCH;
      end
      ST_RESP: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_audio_r, res_bank_r, res_rdata_r};
          out_last_nxt  = res_done_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_READ;
      fcnt_r      <= '0;
      pc_r        <= '0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      rd_zero_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      fcnt_r      <= fcnt_nxt;
      pc_r        <= pc_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_zero_r   <= rd_zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r       <= buf_nxt;
    addr_r      <= addr_nxt;
    wdata_r     <= wdata_nxt;
    keys_r      <= keys_nxt;
    res_rdata_r <= res_rdata_nxt;
    res_done_r  <= res_done_nxt;
    res_bank_r  <= res_bank_nxt;
    res_audio_r <= res_audio_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  a_copy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> ($past(state_r) == ST_LAST && mode_r == MODE_INSTR))
    else $error("copy step not preceded by instruction fetch");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(INSTR_PER_FRAME))
    else $error("instruction count past frame length");

  a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (fcnt_r <= fetch_last))
    else $error("fetch counter past last byte");

  a_last_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LAST || state_r == ST_COPY) |-> rd_pend_r)
    else $error("byte consumed without a read in flight");

  a_resp_issues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && (!out_valid_r || out_tready)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("result not moved to output register");
`endif

endmodule

@@ tb/byte_byte_jump_frame_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_byte_jump_frame_engine_unit_tb
// Drives loads, reads, unused opcodes and one full run-frame on a random
// copy-and-jump loop. A shadow memory predicts every result, which is then
// checked field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------

typedef struct packed {
  bit [15:0] audio_page;
  bit [7:0]  screen_bank;
  bit [7:0]  read_data;
  bit        frame_done;
} bbj_result_t;

class bbj_result_board;
  typedef bit [bbj_pkg::AEXT_W-1:0] aext_t;

  bit [7:0]    shadow_mem [bit [23:0]];
  bit [23:0]   written_addrs[$];
  bit [23:0]   pc;
  bbj_result_t expected_results[$];
  int unsigned mismatches;

  // Bytes above the top of memory read as zero.
  function bit [7:0] peek(aext_t a);
    if ((a >> bbj_pkg::ADDR_BITS) != 0) return 8'h00;
    if (!shadow_mem.exists(a[23:0])) return 8'h00;
    return shadow_mem[a[23:0]];
  endfunction

  function void store(aext_t a, bit [7:0] v);
    if ((a >> bbj_pkg::ADDR_BITS) != 0) return;
    if (!shadow_mem.exists(a[23:0])) written_addrs.push_back(a[23:0]);
    shadow_mem[a[23:0]] = v;
  endfunction

  function bit [23:0] fetch24(aext_t a);
    return {peek(a), peek(aext_t'(a + 1)), peek(aext_t'(a + 2))};
  endfunction

  function void run_frame(bit [15:0] keys);
    aext_t     at;
    bit [23:0] src;
    bit [23:0] dst;
    bit [23:0] jmp;
    store(aext_t'(0), keys[15:8]);
    store(aext_t'(1), keys[7:0]);
    pc = fetch24(aext_t'(2));
    for (int unsigned n = 0; n < bbj_pkg::INSTR_PER_FRAME; n++) begin
      at  = {1'b0, pc};
      src = fetch24(at);
      dst = fetch24(aext_t'(at + 3));
      jmp = fetch24(aext_t'(at + 6));
      store({1'b0, dst}, peek({1'b0, src}));
      pc = jmp;
    end
  endfunction

  function void note_item(bit [1:0] op, bit [23:0] addr, bit [7:0] wdata, bit [15:0] keys);
    bbj_result_t r = '0;
    case (op)
      bbj_pkg::OP_LOAD: store({1'b0, addr}, wdata);
      bbj_pkg::OP_READ: r.read_data = peek({1'b0, addr});
      bbj_pkg::OP_FRAME: begin
        run_frame(keys);
        r.frame_done  = 1'b1;
        r.screen_bank = peek(aext_t'(5));
        r.audio_page  = {peek(aext_t'(6)), peek(aext_t'(7))};
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endfunction

  function void check_result(bit [31:0] data, bit last);
    bbj_result_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result: tdata %08h tlast %0b", data, last);
      mismatches++;
      return;
    end
    e = expected_results.pop_front();
    if (data[7:0] != e.read_data) begin
      $error("read_data: expected %02h, got %02h", e.read_data, data[7:0]);
      mismatches++;
    end
    if (last != e.frame_done) begin
      $error("frame_done: expected %0b, got %0b", e.frame_done, last);
      mismatches++;
    end
    if (data[15:8] != e.screen_bank) begin
      $error("screen_bank: expected %02h, got %02h", e.screen_bank, data[15:8]);
      mismatches++;
    end
    if (data[31:16] != e.audio_page) begin
      $error("audio_page: expected %04h, got %04h", e.audio_page, data[31:16]);
      mismatches++;
    end
  endfunction
endclass

module byte_byte_jump_frame_engine_unit_tb;
  import bbj_pkg::*;

  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned MEM_TOP        = 2 ** ADDR_BITS;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000000;
  localparam int unsigned TAIL_ITEMS     = 55;
  localparam int unsigned HOLD_AT_ITEM   = 5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // address[23:0], write_data[31:24], key_map[47:32]
  logic [1:0]  in_tuser = '0;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // read_data[7:0], screen_bank[15:8], audio_page[31:16]
  logic        out_tlast;       // frame_done

  bbj_result_board board = new();

  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req = 1'b0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;
  int unsigned ready_tick = 0;
  int unsigned ring [3];
  int unsigned data_addrs [4];

  byte_byte_jump_frame_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Close a burst with a random gap, then pick the next burst length.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [23:0] addr,
                           input logic [7:0] wdata, input logic [15:0] keys);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {keys, wdata, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_item(op, addr, wdata, keys);
    pace();
  endtask

  // Read only bytes that hold a defined value.
  task automatic read_written();
    send_item(OP_READ, board.written_addrs[$urandom_range(0, board.written_addrs.size() - 1)],
              8'($urandom), 16'($urandom));
  endtask

  function automatic bit in_ring(int unsigned a);
    for (int k = 0; k < 3; k++)
      if (a >= ring[k] && a < ring[k] + 9) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int unsigned fresh_addr();
    int unsigned a;
    do a = $urandom_range(8, MEM_TOP - 1); while (in_ring(a));
    return a;
  endfunction

  task automatic directed_items();
    send_item(OP_LOAD,   24'h000000, 8'hFF, 16'h0000);
    send_item(OP_LOAD,   24'hFFFFFF, 8'h00, 16'hFFFF);
    send_item(OP_LOAD,   24'h800000, 8'hA5, 16'h8000);
    send_item(OP_LOAD,   24'h7FFFFF, 8'h5A, 16'h7FFF);
    send_item(OP_READ,   24'h000000, 8'h00, 16'hFFFF);
    send_item(OP_READ,   24'hFFFFFF, 8'hFF, 16'h0000);
    send_item(OP_READ,   24'h800000, 8'h00, 16'h5555);
    send_item(OP_READ,   24'h7FFFFF, 8'h00, 16'hAAAA);
    send_item(OP_UNUSED, 24'hFFFFFF, 8'hFF, 16'hFFFF);
    send_item(OP_UNUSED, 24'h000000, 8'h00, 16'h0000);
    send_item(OP_LOAD,   24'h555555, 8'h55, 16'h0001);
    send_item(OP_LOAD,   24'hAAAAAA, 8'hAA, 16'h0100);
    send_item(OP_READ,   24'h555555, 8'h00, 16'h0000);
    send_item(OP_READ,   24'hAAAAAA, 8'h00, 16'h0000);
    // overwrite, then read back the newer byte
    send_item(OP_LOAD,   24'h000000, 8'h3C, 16'h0000);
    send_item(OP_READ,   24'h000000, 8'h00, 16'h0000);
  endtask

  // Load a three-step copy loop whose bytes and sources are all defined, and
  // run one frame on it. The first step sits at the top of memory, so its
  // jump field runs past the last byte and reads a zero low byte.
  task automatic frame_program();
    bit [71:0]   fields;
    int unsigned src;
    int unsigned dst;
    int unsigned jmp;
    int unsigned a;
    int unsigned start;
    ring[0] = MEM_TOP - 8;
    ring[1] = $urandom_range(1, (MEM_TOP >> 8) - 2) << 8;
    ring[2] = ring[1] + 16;
    foreach (data_addrs[k]) data_addrs[k] = fresh_addr();
    start = ring[$urandom_range(0, 2)];
    for (int b = 2; b < 8; b++) begin
      if (b == 2 || b == 3 || b == 4)
        send_item(OP_LOAD, 24'(b), 8'(start >> (8 * (4 - b))), 16'($urandom));
      else
        send_item(OP_LOAD, 24'(b), 8'($urandom), 16'($urandom));
    end
    foreach (data_addrs[k])
      send_item(OP_LOAD, 24'(data_addrs[k]), 8'($urandom), 16'($urandom));
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0: src = $urandom_range(0, 1);
        1: src = data_addrs[$urandom_range(0, 3)];
        2: src = $urandom_range(2, 7);
        default: src = ring[$urandom_range(0, 2)] + $urandom_range(0, 7);
      endcase
      case ($urandom_range(0, 2))
        0: dst = $urandom_range(5, 7);
        1: dst = data_addrs[$urandom_range(0, 3)];
        default: dst = fresh_addr();
      endcase
      // make sure keys reach the reported bytes
      if (k == 0) begin
        src = $urandom_range(0, 1);
        dst = $urandom_range(5, 7);
      end
      jmp = ring[(k + 1) % 3];
      fields = {src[23:0], dst[23:0], jmp[23:0]};
      for (int b = 0; b < 9; b++) begin
        a = ring[k] + b;
        if (a < MEM_TOP) send_item(OP_LOAD, 24'(a), fields[71 - 8 * b -: 8], 16'($urandom));
        if ($urandom_range(0, 4) == 0) read_written();
      end
    end
    send_item(OP_FRAME, 24'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic random_tail();
    int unsigned r;
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      // hold off the receiver while the sender keeps offering
      if (i == HOLD_AT_ITEM) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 25)
        send_item(OP_LOAD, 24'($urandom), 8'($urandom), 16'($urandom));
      else if (r < 40)
        send_item(OP_LOAD,
                  board.written_addrs[$urandom_range(0, board.written_addrs.size() - 1)],
                  8'($urandom), 16'($urandom));
      else if (r < 88)
        read_written();
      else
        send_item(OP_UNUSED, 24'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  // Receiver: stall on a changing pattern, with one long hold-off on request.
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end
      mode_left--;
      ready_tick++;
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (ready_tick % 4 == 0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    directed_items();
    frame_program();
    random_tail();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
